// ===== design/q2e_pkg.sv =====
package q2e_pkg;

   // Internal formats: components Q.22, products Q.44, angles degrees * 2^20
   localparam int IntFrac = 22;
   localparam int DegFrac = 20;
   localparam int OutShift = 13;
   localparam int ProdW = 52;   // products and sums of products (Q.44)
   localparam int CordW = 56;   // CORDIC vector word with growth headroom
   localparam int AngW = 32;    // angle accumulator
   localparam int CompW = 28;   // Q.22 component with sign headroom
   localparam int SqrtW = 24;   // cosine root, Q.22 up to 1.0
   localparam int ThrW = 24;
   localparam logic [ThrW-1:0] ThrReset = 24'd8388600;

   typedef enum logic [1:0] {
      LOCK_NONE = 2'd0,
      LOCK_NEG  = 2'd1,
      LOCK_POS  = 2'd2
   } lock_type;

   localparam logic signed [AngW-1:0] Deg90 = 32'sd94371840;
   localparam logic signed [AngW-1:0] Deg180 = 32'sd188743680;
   localparam logic signed [AngW+1:0] Deg360 = 34'sd377487360;

   // arctangent of 2^-k, degrees * 2^20
   function automatic logic signed [AngW-1:0] atan_deg(input logic [4:0] k);
      logic signed [AngW-1:0] r;
      unique case (k)
         5'd0: r = 32'sd47185920;  5'd1: r = 32'sd27855475;
         5'd2: r = 32'sd14718068;  5'd3: r = 32'sd7471121;
         5'd4: r = 32'sd3750058;   5'd5: r = 32'sd1876857;
         5'd6: r = 32'sd938658;    5'd7: r = 32'sd469357;
         5'd8: r = 32'sd234682;    5'd9: r = 32'sd117342;
         5'd10: r = 32'sd58671;    5'd11: r = 32'sd29335;
         5'd12: r = 32'sd14668;    5'd13: r = 32'sd7334;
         5'd14: r = 32'sd3667;     5'd15: r = 32'sd1833;
         5'd16: r = 32'sd917;      5'd17: r = 32'sd458;
         5'd18: r = 32'sd229;      5'd19: r = 32'sd115;
         5'd20: r = 32'sd57;       5'd21: r = 32'sd29;
         5'd22: r = 32'sd14;       5'd23: r = 32'sd7;
         5'd24: r = 32'sd4;        5'd25: r = 32'sd2;
         5'd26: r = 32'sd1;
         default: r = '0;
      endcase
      return r;
   endfunction

endpackage

// ===== design/q2e_cordic.sv =====
// Pipelined vectoring CORDIC: atan2(y, x) in degrees * 2^20, one stage per
// register. Takes one vector per cycle.
module q2e_cordic #(
   parameter int STAGES = 16
) (
   input  logic                                clock,
   input  logic signed [q2e_pkg::CordW-1:0]    in_y,
   input  logic signed [q2e_pkg::CordW-1:0]    in_x,
   output logic signed [q2e_pkg::AngW-1:0]     out_angle
);

   localparam int W = q2e_pkg::CordW;
   localparam int A = q2e_pkg::AngW;

   logic signed [W-1:0] x_ff   [STAGES+1];
   logic signed [W-1:0] y_ff   [STAGES+1];
   logic signed [A-1:0] ang_ff [STAGES+1];
   logic                zero_ff[STAGES+1];

   // pre-rotate into the right half plane
   always_ff @(posedge clock) begin
      zero_ff[0] <= (in_x == '0) && (in_y == '0);
      if (in_x < 0) begin
         x_ff[0]   <= -in_x;
         y_ff[0]   <= -in_y;
         ang_ff[0] <= (in_y >= 0) ? q2e_pkg::Deg180 : -q2e_pkg::Deg180;
      end else begin
         x_ff[0]   <= in_x;
         y_ff[0]   <= in_y;
         ang_ff[0] <= '0;
      end
   end

   // micro-rotation stages
   for (genvar i = 0; i < STAGES; i++) begin : g_stage
      localparam logic [4:0] K = 5'(i % 32);
      always_ff @(posedge clock) begin
         zero_ff[i+1] <= zero_ff[i];
         if (y_ff[i] >= 0) begin
            x_ff[i+1]   <= x_ff[i] + (y_ff[i] >>> K);
            y_ff[i+1]   <= y_ff[i] - (x_ff[i] >>> K);
            ang_ff[i+1] <= ang_ff[i] + q2e_pkg::atan_deg(K);
         end else begin
            x_ff[i+1]   <= x_ff[i] - (y_ff[i] >>> K);
            y_ff[i+1]   <= y_ff[i] + (x_ff[i] >>> K);
            ang_ff[i+1] <= ang_ff[i] - q2e_pkg::atan_deg(K);
         end
      end
   end

   assign out_angle = zero_ff[STAGES] ? '0 : ang_ff[STAGES];

endmodule

// ===== design/q2e_isqrt.sv =====
// Pipelined integer square root, one result bit per stage.
// One operand per cycle; side data rides along.
module q2e_isqrt #(
   parameter int SIDE_W = 8
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              in_valid,
   input  logic [2*q2e_pkg::SqrtW-1:0]       in_rad,
   input  logic [SIDE_W-1:0]                 in_side,
   output logic                              out_valid,
   output logic [q2e_pkg::SqrtW-1:0]         out_root,
   output logic [SIDE_W-1:0]                 out_side
);

   localparam int R = q2e_pkg::SqrtW;
   localparam int N = 2 * R;

   logic              v_ff    [R+1];
   logic [N-1:0]      rem_ff  [R+1];
   logic [R-1:0]      root_ff [R+1];
   logic [SIDE_W-1:0] side_ff [R+1];

   always_comb begin
      v_ff[0]    = in_valid;
      rem_ff[0]  = in_rad;
      root_ff[0] = '0;
      side_ff[0] = in_side;
   end

   // restoring step: try the next root bit
   for (genvar i = 0; i < R; i++) begin : g_bit
      localparam int B = R - 1 - i;
      logic [N+1:0] trial;
      always_comb begin
         trial = ({2'b00, N'(root_ff[i])} << (B + 1)) + ({2'b00, N'(1)} << (2 * B));
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[i+1] <= 1'b0;
         end else begin
            v_ff[i+1] <= v_ff[i];
         end
         side_ff[i+1] <= side_ff[i];
         if ({2'b00, rem_ff[i]} >= trial) begin
            rem_ff[i+1]  <= rem_ff[i] - N'(trial);
            root_ff[i+1] <= root_ff[i] | (R'(1) << B);
         end else begin
            rem_ff[i+1]  <= rem_ff[i];
            root_ff[i+1] <= root_ff[i];
         end
      end
   end

   assign out_valid = v_ff[R];
   assign out_root  = root_ff[R];
   assign out_side  = side_ff[R];

endmodule

// ===== design/quaternion_to_euler.sv =====
// Quaternion to Euler angles with gimbal-lock handling.
// Input: drive req_quat_w/x/y/z (signed Q2.14 at 16 bits) with start high;
// the transaction is taken at any edge where busy is low. busy stays low,
// so a new quaternion may enter every cycle.
// Output: rsp_valid is high for one cycle with rsp_pitch_deg, rsp_yaw_deg,
// rsp_roll_deg (degrees * 128) and rsp_lock_case. The receiver cannot stall.
// Pipeline: 4 + SqrtW + (CORDIC_STAGES + 1) + 3 register stages, 48 at the
// defaults. The square root pipeline (24 bits, one per stage) and the CORDIC
// stages make up most of them. Throughput is one transaction per cycle.
// csr_wr_en/csr_wr_data write the 24-bit singularity threshold; write only
// while no transaction is in flight. Reset sets the threshold to 8388600
// and clears all valid bits; data in flight is dropped.
module quaternion_to_euler #(
   parameter int COMPONENT_BITS = 16,
   parameter int CORDIC_STAGES  = 16
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  logic signed [COMPONENT_BITS-1:0] req_quat_w,
   input  logic signed [COMPONENT_BITS-1:0] req_quat_x,
   input  logic signed [COMPONENT_BITS-1:0] req_quat_y,
   input  logic signed [COMPONENT_BITS-1:0] req_quat_z,
   input  logic                             csr_wr_en,
   input  logic [23:0]                      csr_wr_data,
   output logic                             rsp_valid,
   output logic signed [14:0]               rsp_pitch_deg,
   output logic signed [15:0]               rsp_yaw_deg,
   output logic signed [15:0]               rsp_roll_deg,
   output logic [1:0]                       rsp_lock_case
);

   localparam int CW = q2e_pkg::CompW;
   localparam int PW = q2e_pkg::ProdW;
   localparam int W  = q2e_pkg::CordW;
   localparam int A  = q2e_pkg::AngW;
   localparam int SR = q2e_pkg::SqrtW;
   localparam int Sh = q2e_pkg::IntFrac - (COMPONENT_BITS - 2);
   localparam logic signed [PW-1:0] One = PW'(1) << (2 * q2e_pkg::IntFrac);

   logic [23:0] thr_ff;

   // hold the threshold register
   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= q2e_pkg::ThrReset;
      end else if (csr_wr_en) begin
         thr_ff <= csr_wr_data;
      end
   end

   assign busy = 1'b0;

   // scale components to Q.22
   function automatic logic signed [CW-1:0] to_q22(input logic signed [COMPONENT_BITS-1:0] v);
      logic signed [COMPONENT_BITS+CW-1:0] e;
      e = (COMPONENT_BITS + CW)'(v);
      if (Sh >= 0) begin
         return CW'(e <<< (Sh >= 0 ? Sh : 0));
      end else begin
         return CW'(e >>> (Sh < 0 ? -Sh : 0));
      end
   endfunction

   // stage 1: register scaled components
   logic                 v1_ff;
   logic signed [CW-1:0] w1_ff, x1_ff, y1_ff, z1_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else begin
         v1_ff <= start;
      end
      w1_ff <= to_q22(req_quat_w);
      x1_ff <= to_q22(req_quat_x);
      y1_ff <= to_q22(req_quat_y);
      z1_ff <= to_q22(req_quat_z);
   end

   // stage 2: products
   logic                 v2_ff;
   logic signed [PW-1:0] zx_ff, wy_ff, wz_ff, xy_ff, yy_ff, zz_ff, wx_ff, yz_ff, xx_ff;
   logic signed [CW-1:0] w2_ff, x2_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else begin
         v2_ff <= v1_ff;
      end
      zx_ff <= PW'(z1_ff) * PW'(x1_ff);
      wy_ff <= PW'(w1_ff) * PW'(y1_ff);
      wz_ff <= PW'(w1_ff) * PW'(z1_ff);
      xy_ff <= PW'(x1_ff) * PW'(y1_ff);
      yy_ff <= PW'(y1_ff) * PW'(y1_ff);
      zz_ff <= PW'(z1_ff) * PW'(z1_ff);
      wx_ff <= PW'(w1_ff) * PW'(x1_ff);
      yz_ff <= PW'(y1_ff) * PW'(z1_ff);
      xx_ff <= PW'(x1_ff) * PW'(x1_ff);
      w2_ff <= w1_ff;
      x2_ff <= x1_ff;
   end

   // stage 3: sums, lock decision, pitch term
   logic                 v3_ff;
   logic signed [W-1:0]  yawy_ff, yawx_ff, rolly_ff, rollx_ff, v3v_ff, xq_ff, wq_ff;
   logic [1:0]           lock3_ff;
   logic [2*(SR+1)-1:0]  av_sq_ff;
   logic signed [PW-1:0] s_in, thr_in, v_in;
   logic [q2e_pkg::SqrtW:0] av_in;
   always_comb begin
      s_in   = zx_ff - wy_ff;
      thr_in = PW'({1'b0, thr_ff}) <<< (2 * q2e_pkg::IntFrac - 24);
      v_in   = (s_in <<< 1) >>> q2e_pkg::IntFrac;
      av_in  = v_in[PW-1] ? (SR+1)'(-v_in) : (SR+1)'(v_in);
   end
   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else begin
         v3_ff <= v2_ff;
      end
      yawy_ff  <= W'((wz_ff + xy_ff) <<< 1);
      yawx_ff  <= W'(One - ((yy_ff + zz_ff) <<< 1));
      rolly_ff <= -W'((wx_ff + yz_ff) <<< 1);
      rollx_ff <= W'(One - ((xx_ff + yy_ff) <<< 1));
      v3v_ff   <= W'(v_in);
      xq_ff    <= W'(x2_ff);
      wq_ff    <= W'(w2_ff);
      priority if (s_in < -thr_in) lock3_ff <= q2e_pkg::LOCK_NEG;
      else if (s_in > thr_in)      lock3_ff <= q2e_pkg::LOCK_POS;
      else                         lock3_ff <= q2e_pkg::LOCK_NONE;
      av_sq_ff <= (2*(SR+1))'(av_in) * (2*(SR+1))'(av_in);
   end

   // stage 4: radicand for the cosine
   logic                 v4_ff;
   logic [2*SR-1:0]      rad_ff;
   logic signed [W-1:0]  d4_ff [7];
   logic [1:0]           lock4_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
      end else begin
         v4_ff <= v3_ff;
      end
      rad_ff <= (av_sq_ff >= (2*(SR+1))'(One)) ? '0 : (2*SR)'((2*(SR+1))'(One) - av_sq_ff);
      d4_ff[0] <= yawy_ff;  d4_ff[1] <= yawx_ff;
      d4_ff[2] <= rolly_ff; d4_ff[3] <= rollx_ff;
      d4_ff[4] <= v3v_ff;   d4_ff[5] <= xq_ff;
      d4_ff[6] <= wq_ff;
      lock4_ff <= lock3_ff;
   end

   // square root pipeline with all other operands riding along
   localparam int SideW = 7 * W + 2;
   logic [SideW-1:0] side_in, side_out;
   logic [SR-1:0]    cos_root;
   logic             vs;
   assign side_in = {d4_ff[0], d4_ff[1], d4_ff[2], d4_ff[3], d4_ff[4], d4_ff[5],
                     d4_ff[6], lock4_ff};
   q2e_isqrt #(.SIDE_W(SideW)) u_isqrt (
      .clock(clock), .reset(reset), .in_valid(v4_ff), .in_rad(rad_ff),
      .in_side(side_in), .out_valid(vs), .out_root(cos_root), .out_side(side_out)
   );

   logic [1:0]          locks;
   logic signed [W-1:0] s_yawy, s_yawx, s_rolly, s_rollx, s_v, s_x, s_w;
   assign {s_yawy, s_yawx, s_rolly, s_rollx, s_v, s_x, s_w, locks} = side_out;

   // CORDIC engines: yaw, normal roll, pole atan2(x, w), pitch
   logic signed [A-1:0] yaw_a, pr_a, xw_a;
   q2e_cordic #(.STAGES(CORDIC_STAGES)) u_yaw (
      .clock(clock), .in_y(s_yawy), .in_x(s_yawx), .out_angle(yaw_a)
   );
   q2e_cordic #(.STAGES(CORDIC_STAGES)) u_roll (
      .clock(clock), .in_y(s_rolly), .in_x(s_rollx), .out_angle(pr_a)
   );
   q2e_cordic #(.STAGES(CORDIC_STAGES)) u_pole (
      .clock(clock), .in_y(s_x), .in_x(s_w), .out_angle(xw_a)
   );
   logic signed [A-1:0] pitch_a;
   q2e_cordic #(.STAGES(CORDIC_STAGES)) u_pitch (
      .clock(clock), .in_y(s_v), .in_x(W'({1'b0, cos_root})), .out_angle(pitch_a)
   );

   // delay valid and lock case alongside the CORDIC pipelines
   logic       vc_ff   [CORDIC_STAGES+1];
   logic [1:0] lockc_ff[CORDIC_STAGES+1];
   always_ff @(posedge clock) begin
      if (reset) begin
         vc_ff[0] <= 1'b0;
      end else begin
         vc_ff[0] <= vs;
      end
      lockc_ff[0] <= locks;
   end
   for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_dly
      always_ff @(posedge clock) begin
         if (reset) begin
            vc_ff[i+1] <= 1'b0;
         end else begin
            vc_ff[i+1] <= vc_ff[i];
         end
         lockc_ff[i+1] <= lockc_ff[i];
      end
   end

   // stage A: raw pole roll, pitch selection
   logic                vA_ff;
   logic [1:0]          lockA_ff;
   logic signed [A+1:0] rawA_ff;
   logic signed [A-1:0] yawA_ff, pitchA_ff, rollnA_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         vA_ff <= 1'b0;
      end else begin
         vA_ff <= vc_ff[CORDIC_STAGES];
      end
      lockA_ff  <= lockc_ff[CORDIC_STAGES];
      yawA_ff   <= yaw_a;
      rollnA_ff <= pr_a;
      unique case (lockc_ff[CORDIC_STAGES])
         q2e_pkg::LOCK_NEG: begin
            pitchA_ff <= -q2e_pkg::Deg90;
            rawA_ff   <= -(A+2)'(yaw_a) - ((A+2)'(xw_a) <<< 1);
         end
         q2e_pkg::LOCK_POS: begin
            pitchA_ff <= q2e_pkg::Deg90;
            rawA_ff   <= (A+2)'(yaw_a) - ((A+2)'(xw_a) <<< 1);
         end
         default: begin
            pitchA_ff <= pitch_a;
            rawA_ff   <= '0;
         end
      endcase
   end

   // stage B: wrap pole roll into -180..180 (|raw| stays below 2.5 turns);
   // pick the whole-turn offset from parallel compares, then add it once
   localparam logic signed [A+1:0] Half  = (A+2)'(q2e_pkg::Deg180);
   localparam logic signed [A+1:0] Full  = q2e_pkg::Deg360;
   localparam logic signed [A+1:0] Half3 = Full + Half;
   logic signed [A+1:0] r_off, r2;
   always_comb begin
      priority if (rawA_ff > Half3) r_off = -(Full <<< 1);
      else if (rawA_ff > Half)      r_off = -Full;
      else if (rawA_ff >= -Half)    r_off = '0;
      else if (rawA_ff >= -Half3)   r_off = Full;
      else                          r_off = Full <<< 1;
      r2 = rawA_ff + r_off;
   end
   logic                vB_ff;
   logic [1:0]          lockB_ff;
   logic signed [A-1:0] yawB_ff, pitchB_ff, rollB_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         vB_ff <= 1'b0;
      end else begin
         vB_ff <= vA_ff;
      end
      lockB_ff  <= lockA_ff;
      yawB_ff   <= yawA_ff;
      pitchB_ff <= pitchA_ff;
      rollB_ff  <= (lockA_ff == q2e_pkg::LOCK_NONE) ? rollnA_ff : A'(r2);
   end

   // round half up to degrees * 128 and clamp
   function automatic logic signed [A-1:0] to_out(input logic signed [A-1:0] a,
                                                   input logic signed [A-1:0] lim);
      logic signed [A:0] v;
      v = ((A+1)'(a) + (A+1)'(1 <<< (q2e_pkg::OutShift - 1))) >>> q2e_pkg::OutShift;
      if (v > (A+1)'(lim)) v = (A+1)'(lim);
      if (v < -(A+1)'(lim)) v = -(A+1)'(lim);
      return A'(v);
   endfunction

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid <= 1'b0;
      end else begin
         rsp_valid <= vB_ff;
      end
      rsp_pitch_deg <= 15'(to_out(pitchB_ff, 32'sd11520));
      rsp_yaw_deg   <= 16'(to_out(yawB_ff, 32'sd23040));
      rsp_roll_deg  <= 16'(to_out(rollB_ff, 32'sd23040));
      rsp_lock_case <= lockB_ff;
   end

endmodule

// ===== design/q2e_checker.sv =====
// Port-level checks on busy and the result channel.
module q2e_checker (
   input logic              clock,
   input logic              reset,
   input logic              busy,
   input logic              rsp_valid,
   input logic signed [14:0] rsp_pitch_deg,
   input logic signed [15:0] rsp_yaw_deg,
   input logic signed [15:0] rsp_roll_deg,
   input logic [1:0]        rsp_lock_case
);

   a_no_busy: assert property (@(posedge clock) busy == 1'b0)
      else $error("busy raised");
   a_rst_quiet: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result after reset");
   a_lock_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_lock_case == q2e_pkg::LOCK_NONE ||
                     rsp_lock_case == q2e_pkg::LOCK_NEG ||
                     rsp_lock_case == q2e_pkg::LOCK_POS))
      else $error("bad lock case");
   a_pole_pitch: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_lock_case == q2e_pkg::LOCK_POS |-> rsp_pitch_deg == 15'sd11520)
      else $error("pole pitch wrong");
   a_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_roll_deg <= 16'sd23040 && rsp_roll_deg >= -16'sd23040)
      else $error("roll out of range");

endmodule

bind quaternion_to_euler q2e_checker u_q2e_checker (
   .clock(clock), .reset(reset), .busy(busy), .rsp_valid(rsp_valid),
   .rsp_pitch_deg(rsp_pitch_deg), .rsp_yaw_deg(rsp_yaw_deg),
   .rsp_roll_deg(rsp_roll_deg), .rsp_lock_case(rsp_lock_case)
);
